### rtl/core/hoeb_pkg.sv
// Shared constants for the half-edge opposite table engine.
// No dependencies; used by the top level and sized into the generic RAM.
package hoeb_pkg;

    localparam int MAX_HALF_EDGES = 1024;
    localparam int VERTEX_BITS    = 16;
    localparam int HE_BITS        = $clog2(MAX_HALF_EDGES);
    localparam int HE_CNT_BITS    = HE_BITS + 1;
    localparam int OPP_BITS       = HE_BITS + 1;
    localparam int VPE_BITS       = 4;
    localparam int ECNT_BITS      = 10;
    localparam int TOTAL_BITS     = ECNT_BITS + VPE_BITS;
    localparam int OP_BITS        = 2;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 10;

    localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VPE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ECNT = 1'b1;

    typedef logic [HE_BITS-1:0]     he_idx_t;
    typedef logic [HE_CNT_BITS-1:0] he_cnt_t;
    typedef logic [VERTEX_BITS-1:0] vertex_t;
    typedef logic [OPP_BITS-1:0]    opp_entry_t;

endpackage

### rtl/core/half_edge_opposite_builder.sv
// Half-edge opposite table engine: vertex store, opposite store, build sequencer.
// Depends on hoeb_pkg and hoeb_ram.
// Load and no-op results are registered on acceptance; a query adds one opposite-table read; one request at a time.
// Build: clear sweep of the opposite table, then for each half-edge an opposite and vertex read; an unlinked one
// scans the candidate half-edges in order and, on a match, makes 2 link writes (S_W1, then S_W2).
// Reset: synchronous, active low; then a clear sweep of the opposite table with s_ready low.
module half_edge_opposite_builder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [hoeb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [hoeb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [hoeb_pkg::OP_BITS-1:0]         s_op,
    input  logic [hoeb_pkg::HE_BITS-1:0]         s_half_edge_index,
    input  logic [hoeb_pkg::VERTEX_BITS-1:0]     s_vertex_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [hoeb_pkg::HE_BITS-1:0]         m_opposite_index,
    output logic                                 m_is_border,
    output logic                                 m_status
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_QRD  = 4'd2;
    localparam logic [3:0] S_HRD  = 4'd3;
    localparam logic [3:0] S_HCHK = 4'd4;
    localparam logic [3:0] S_GRD  = 4'd5;
    localparam logic [3:0] S_GCHK = 4'd6;
    localparam logic [3:0] S_W1   = 4'd7;
    localparam logic [3:0] S_W2   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [hoeb_pkg::VPE_BITS-1:0]  vpe_reg, vpe_next;
    logic [hoeb_pkg::ECNT_BITS-1:0] ecnt_reg, ecnt_next;
    hoeb_pkg::he_cnt_t clr_reg, clr_next;
    logic              build_pending_reg, build_pending_next;
    hoeb_pkg::he_cnt_t total_reg, total_next;
    hoeb_pkg::he_cnt_t h_reg, h_next;
    hoeb_pkg::he_cnt_t g_reg, g_next;
    logic [hoeb_pkg::VPE_BITS-1:0] hc_reg, hc_next;
    logic [hoeb_pkg::VPE_BITS-1:0] gc_reg, gc_next;
    hoeb_pkg::vertex_t a_reg, a_next;
    hoeb_pkg::vertex_t b_reg, b_next;

    logic                     m_valid_reg, m_valid_next;
    hoeb_pkg::he_idx_t        m_opp_reg, m_opp_next;
    logic                     m_border_reg, m_border_next;
    logic                     m_status_reg, m_status_next;

    logic                     accept;
    logic                     out_load;
    hoeb_pkg::he_idx_t        out_opp;
    logic                     out_border;
    logic                     out_status;
    logic                     adv_h;
    logic [hoeb_pkg::TOTAL_BITS-1:0] total_w;
    logic [hoeb_pkg::VPE_BITS-1:0]   vpe_m1;

    hoeb_pkg::vertex_t    vtx0_rd, vtx1_rd;
    hoeb_pkg::he_idx_t    vtx0_raddr, vtx1_raddr;
    logic                 vtx_we;
    hoeb_pkg::opp_entry_t opp_rd, opp_wdata;
    hoeb_pkg::he_idx_t    opp_raddr, opp_waddr;
    logic                 opp_we;

    // successor within the element: wraps to the first corner after the last
    function automatic hoeb_pkg::he_idx_t next_he(
        input hoeb_pkg::he_cnt_t             idx,
        input logic [hoeb_pkg::VPE_BITS-1:0] corner,
        input logic [hoeb_pkg::VPE_BITS-1:0] last
    );
        hoeb_pkg::he_cnt_t r;
        if (corner == last) begin
            r = idx - hoeb_pkg::HE_CNT_BITS'(last);
        end else begin
            r = idx + hoeb_pkg::HE_CNT_BITS'(1);
        end
        return r[hoeb_pkg::HE_BITS-1:0];
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign vpe_m1  = vpe_reg - hoeb_pkg::VPE_BITS'(1);
    assign total_w = hoeb_pkg::TOTAL_BITS'(ecnt_reg) * hoeb_pkg::TOTAL_BITS'(vpe_reg);

    // memories
    assign vtx_we     = accept && (s_op == hoeb_pkg::OP_LOAD);
    assign vtx0_raddr = (state_reg == S_GRD) ? g_reg[hoeb_pkg::HE_BITS-1:0]
                                             : h_reg[hoeb_pkg::HE_BITS-1:0];
    assign vtx1_raddr = (state_reg == S_GRD) ? next_he(g_reg, gc_reg, vpe_m1)
                                             : next_he(h_reg, hc_reg, vpe_m1);

    hoeb_ram #(.WIDTH(hoeb_pkg::VERTEX_BITS), .DEPTH(hoeb_pkg::MAX_HALF_EDGES)) u_vtx0 (
        .aclk  (aclk),
        .we    (vtx_we),
        .waddr (s_half_edge_index),
        .wdata (s_vertex_index),
        .raddr (vtx0_raddr),
        .rdata (vtx0_rd)
    );

    // mirror copy gives the second read port
    hoeb_ram #(.WIDTH(hoeb_pkg::VERTEX_BITS), .DEPTH(hoeb_pkg::MAX_HALF_EDGES)) u_vtx1 (
        .aclk  (aclk),
        .we    (vtx_we),
        .waddr (s_half_edge_index),
        .wdata (s_vertex_index),
        .raddr (vtx1_raddr),
        .rdata (vtx1_rd)
    );

    assign opp_raddr = (state_reg == S_IDLE) ? s_half_edge_index
                                             : h_reg[hoeb_pkg::HE_BITS-1:0];
    assign opp_we    = (state_reg == S_CLR) || (state_reg == S_W1) || (state_reg == S_W2);

    always_comb begin
        unique case (state_reg)
            S_W1: begin
                opp_waddr = h_reg[hoeb_pkg::HE_BITS-1:0];
                opp_wdata = {1'b1, g_reg[hoeb_pkg::HE_BITS-1:0]};
            end
            S_W2: begin
                opp_waddr = g_reg[hoeb_pkg::HE_BITS-1:0];
                opp_wdata = {1'b1, h_reg[hoeb_pkg::HE_BITS-1:0]};
            end
            default: begin
                opp_waddr = clr_reg[hoeb_pkg::HE_BITS-1:0];
                opp_wdata = '0;
            end
        endcase
    end

    hoeb_ram #(.WIDTH(hoeb_pkg::OPP_BITS), .DEPTH(hoeb_pkg::MAX_HALF_EDGES)) u_opp (
        .aclk  (aclk),
        .we    (opp_we),
        .waddr (opp_waddr),
        .wdata (opp_wdata),
        .raddr (opp_raddr),
        .rdata (opp_rd)
    );

    // configuration
    always_comb begin
        vpe_next  = vpe_reg;
        ecnt_next = ecnt_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                hoeb_pkg::CFG_VPE:  vpe_next  = cfg_data[hoeb_pkg::VPE_BITS-1:0];
                hoeb_pkg::CFG_ECNT: ecnt_next = cfg_data[hoeb_pkg::ECNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        build_pending_next = build_pending_reg;
        total_next         = total_reg;
        h_next             = h_reg;
        hc_next            = hc_reg;
        g_next             = g_reg;
        gc_next            = gc_reg;
        a_next             = a_reg;
        b_next             = b_reg;
        out_load           = 1'b0;
        out_opp            = '0;
        out_border         = 1'b0;
        out_status         = 1'b0;
        adv_h              = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                clr_next = clr_reg + hoeb_pkg::HE_CNT_BITS'(1);
                if (clr_reg == hoeb_pkg::HE_CNT_BITS'(hoeb_pkg::MAX_HALF_EDGES - 1)) begin
                    clr_next           = '0;
                    build_pending_next = 1'b0;
                    if (!build_pending_reg) begin
                        state_next = S_IDLE;
                    end else if (total_reg == '0) begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        h_next     = '0;
                        hc_next    = '0;
                        state_next = S_HRD;
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        hoeb_pkg::OP_BUILD: begin
                            if (total_w > hoeb_pkg::TOTAL_BITS'(hoeb_pkg::MAX_HALF_EDGES)) begin
                                out_load   = 1'b1;
                                out_status = 1'b1;
                            end else begin
                                total_next         = total_w[hoeb_pkg::HE_CNT_BITS-1:0];
                                build_pending_next = 1'b1;
                                state_next         = S_CLR;
                            end
                        end
                        hoeb_pkg::OP_QUERY: state_next = S_QRD;
                        default:            out_load   = 1'b1;
                    endcase
                end
            end
            S_QRD: begin
                out_load   = 1'b1;
                out_border = !opp_rd[hoeb_pkg::HE_BITS];
                out_opp    = opp_rd[hoeb_pkg::HE_BITS] ? opp_rd[hoeb_pkg::HE_BITS-1:0] : '0;
                state_next = S_IDLE;
            end
            S_HRD: state_next = S_HCHK;
            S_HCHK: begin
                if (opp_rd[hoeb_pkg::HE_BITS]) begin
                    adv_h = 1'b1;
                end else begin
                    a_next     = vtx0_rd;
                    b_next     = vtx1_rd;
                    g_next     = '0;
                    gc_next    = '0;
                    state_next = S_GRD;
                end
            end
            S_GRD: state_next = S_GCHK;
            S_GCHK: begin
                if (vtx0_rd == b_reg && vtx1_rd == a_reg) begin
                    state_next = S_W1;
                end else begin
                    g_next  = g_reg + hoeb_pkg::HE_CNT_BITS'(1);
                    gc_next = (gc_reg == vpe_m1) ? '0 : gc_reg + hoeb_pkg::VPE_BITS'(1);
                    if (g_reg + hoeb_pkg::HE_CNT_BITS'(1) == total_reg) begin
                        adv_h = 1'b1;
                    end else begin
                        state_next = S_GRD;
                    end
                end
            end
            S_W1: state_next = S_W2;
            S_W2: adv_h = 1'b1;
            default: state_next = S_IDLE;
        endcase

        // move to the next half-edge, or finish the build
        if (adv_h) begin
            h_next  = h_reg + hoeb_pkg::HE_CNT_BITS'(1);
            hc_next = (hc_reg == vpe_m1) ? '0 : hc_reg + hoeb_pkg::VPE_BITS'(1);
            if (h_reg + hoeb_pkg::HE_CNT_BITS'(1) == total_reg) begin
                out_load   = 1'b1;
                state_next = S_IDLE;
            end else begin
                state_next = S_HRD;
            end
        end
    end

    // result register; only loaded when the slot is free or draining
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_opp_next    = m_opp_reg;
        m_border_next = m_border_reg;
        m_status_next = m_status_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_opp_next    = out_opp;
            m_border_next = out_border;
            m_status_next = out_status;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_CLR;
            vpe_reg           <= hoeb_pkg::VPE_BITS'(3);
            ecnt_reg          <= '0;
            clr_reg           <= '0;
            build_pending_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            vpe_reg           <= vpe_next;
            ecnt_reg          <= ecnt_next;
            clr_reg           <= clr_next;
            build_pending_reg <= build_pending_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg    <= total_next;
        h_reg        <= h_next;
        hc_reg       <= hc_next;
        g_reg        <= g_next;
        gc_reg       <= gc_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        m_opp_reg    <= m_opp_next;
        m_border_reg <= m_border_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_opposite_index = m_opp_reg;
    assign m_is_border      = m_border_reg;
    assign m_status         = m_status_reg;

endmodule

### rtl/core/hoeb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; width and depth come from its parameters.
module hoeb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
